### rtl/prrts_pkg.sv
`timescale 1ns / 1ps

package prrts_pkg;

  localparam int MAX_TASKS_DEF = 8;

  localparam int DELAY_W = 32;
  localparam int TICK_W  = 32;
  localparam int PRIO_W  = 16;
  localparam int COUNT_W = 4;
  localparam int TASK_W  = 3;

  localparam int S_DATA_W = 32;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 40;
  localparam int M_USER_W = 1;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // operation codes; code three behaves as a reschedule
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_DELAY   = 2'd1;
  localparam logic [1:0] OP_RESCHED = 2'd2;

  // task states
  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_WAITING = 2'd2;

  // priority codes
  localparam logic [1:0] PRIO_MIN = 2'd0;
  localparam logic [1:0] PRIO_MED = 2'd1;
  localparam logic [1:0] PRIO_MAX = 2'd2;
  localparam logic [1:0] PRIO_BAD = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_TASK_COUNT = 1'b0;
  localparam logic REG_TASK_PRIO  = 1'b1;

endpackage

### rtl/priority_round_robin_task_scheduler_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tuser: operation, s_tdata: delay_ticks
// m_*       out  m_tvalid/m_tready  m_tdata: next_task, tick_total, fault
//                                   m_tuser: idle_selected
// apb       in   psel/penable/pready task_count @0x0, task_priorities @0x4
//
// after its transfer an item passes S_HAND, S_MOD (k subtractions, at most MAX_TASKS,
// to bring the scan start below the active task count n), S_SCAN over the n active
// slots and S_DONE before s_tready returns; a tick first counts down the n delays in
// S_TICK. with no active task S_MOD and S_SCAN are skipped.
// the per-task delay and scan steps share one counter/compare path.
// rst is synchronous and clears all task state, delays and counters.
// s_tready is high only between items; a result waits in the output register
// while the next item is accepted, and only the final step stalls on m_tready.

module priority_round_robin_task_scheduler_top #(
  parameter int MAX_TASKS = prrts_pkg::MAX_TASKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [prrts_pkg::S_DATA_W-1:0]      s_tdata,   // [31:0] delay_ticks
  input  logic [prrts_pkg::S_USER_W-1:0]      s_tuser,   // [1:0] operation
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [2:0] next_task, [34:3] tick_total, [35] fault, [39:36] zero
  output logic [prrts_pkg::M_DATA_W-1:0]      m_tdata,
  output logic [prrts_pkg::M_USER_W-1:0]      m_tuser,   // [0] idle_selected
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [prrts_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [prrts_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [prrts_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_HAND,
    S_MOD,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  logic [prrts_pkg::COUNT_W-1:0] task_count;
  logic [prrts_pkg::PRIO_W-1:0]  task_priorities;

  logic [1:0]                    task_state [MAX_TASKS];
  logic [prrts_pkg::DELAY_W-1:0] delay_left [MAX_TASKS];
  logic [CW-1:0]                 running_task;
  logic                          idle_running;
  logic [prrts_pkg::TICK_W-1:0]  tick_counter;
  logic                          fault_latched;

  logic [1:0]                    op;
  logic [prrts_pkg::DELAY_W-1:0] ticks;
  logic [CW-1:0]                 step;
  logic [CW-1:0]                 sidx;

  logic          found_max, found_med, found_min;
  logic [IW-1:0] pick_max, pick_med, pick_min;

  logic [2:0]                    out_task;
  logic                          out_idle;
  logic [prrts_pkg::TICK_W-1:0]  out_ticks;
  logic                          out_fault;

  logic [CW-1:0]                 n_active;
  logic                          have_task;
  logic [IW-1:0]                 rd_idx;
  logic [1:0]                    rd_state;
  logic [prrts_pkg::DELAY_W-1:0] rd_delay;
  logic [2:0]                    prio_idx;
  logic [1:0]                    prio;
  logic [CW-1:0]                 sidx_inc;
  logic                          chosen_ok;
  logic [IW-1:0]                 chosen;
  logic                          cfg_write;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    if (paddr[2] == prrts_pkg::REG_TASK_PRIO) begin
      prdata = {{(prrts_pkg::APB_DATA_W - prrts_pkg::PRIO_W){1'b0}}, task_priorities};
    end else begin
      prdata = {{(prrts_pkg::APB_DATA_W - prrts_pkg::COUNT_W){1'b0}}, task_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count      <= '0;
      task_priorities <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == prrts_pkg::REG_TASK_COUNT) begin
        task_count <= pwdata[prrts_pkg::COUNT_W-1:0];
      end else begin
        task_priorities <= pwdata[prrts_pkg::PRIO_W-1:0];
      end
    end
  end

  // shared datapath
  always_comb begin
    if (32'(task_count) > MAX_TASKS) begin
      n_active = CW'(MAX_TASKS);
    end else begin
      n_active = CW'(task_count);
    end
    have_task = (running_task != CW'(MAX_TASKS));
    rd_idx    = (state == S_HAND) ? running_task[IW-1:0] : sidx[IW-1:0];
    rd_state  = task_state[rd_idx];
    rd_delay  = delay_left[step[IW-1:0]];
    sidx_inc  = sidx + CW'(1);
    // tasks past the eighth have no priority bits and count as min
    prio_idx  = 3'(sidx);
    if (32'(sidx) >= 32'd8) begin
      prio = prrts_pkg::PRIO_MIN;
    end else begin
      prio = task_priorities[2*prio_idx +: 2];
    end
    chosen_ok = found_max | found_med | found_min;
    if (found_max) begin
      chosen = pick_max;
    end else if (found_med) begin
      chosen = pick_med;
    end else begin
      chosen = pick_min;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{(prrts_pkg::M_DATA_W - 36){1'b0}}, out_fault, out_ticks, out_task};
  assign m_tuser  = out_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_task  <= CW'(MAX_TASKS);
      idle_running  <= 1'b0;
      tick_counter  <= '0;
      fault_latched <= 1'b0;
      m_tvalid      <= 1'b0;
      step          <= '0;
      sidx          <= '0;
      found_max     <= 1'b0;
      found_med     <= 1'b0;
      found_min     <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        task_state[i] <= prrts_pkg::ST_READY;
        delay_left[i] <= '0;
      end
    end else begin
      // in S_DONE the final step decides m_tvalid itself
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tuser;
            ticks <= s_tdata;
            step  <= '0;
            if (s_tuser == prrts_pkg::OP_TICK) begin
              tick_counter <= tick_counter + prrts_pkg::TICK_W'(1);
              state        <= S_TICK;
            end else begin
              state <= S_HAND;
            end
          end
        end

        // one task's delay per cycle
        S_TICK: begin
          if (step < n_active) begin
            if (rd_delay != '0) begin
              delay_left[step[IW-1:0]] <= rd_delay - prrts_pkg::DELAY_W'(1);
              if (rd_delay == prrts_pkg::DELAY_W'(1)) begin
                task_state[step[IW-1:0]] <= prrts_pkg::ST_READY;
              end
            end
            step <= step + CW'(1);
          end else begin
            state <= S_HAND;
          end
        end

        // delay request, then hand the running task back
        S_HAND: begin
          if (!idle_running && have_task) begin
            if (op == prrts_pkg::OP_DELAY && ticks != '0) begin
              delay_left[running_task[IW-1:0]] <= ticks;
              task_state[running_task[IW-1:0]] <= prrts_pkg::ST_WAITING;
            end else if (rd_state == prrts_pkg::ST_RUNNING) begin
              task_state[running_task[IW-1:0]] <= prrts_pkg::ST_READY;
            end
          end
          idle_running <= 1'b0;
          sidx         <= have_task ? running_task + CW'(1) : '0;
          step         <= '0;
          found_max    <= 1'b0;
          found_med    <= 1'b0;
          found_min    <= 1'b0;
          state        <= (n_active == '0) ? S_DONE : S_MOD;
        end

        // start index modulo the task count by repeated subtraction
        S_MOD: begin
          if (sidx >= n_active) begin
            sidx <= sidx - n_active;
          end else begin
            state <= S_SCAN;
          end
        end

        // one task slot per cycle, round robin
        S_SCAN: begin
          if (step < n_active) begin
            if (rd_state == prrts_pkg::ST_READY) begin
              case (prio)
                prrts_pkg::PRIO_MAX: begin
                  if (!found_max) begin
                    found_max <= 1'b1;
                    pick_max  <= sidx[IW-1:0];
                  end
                end
                prrts_pkg::PRIO_MED: begin
                  if (!found_med) begin
                    found_med <= 1'b1;
                    pick_med  <= sidx[IW-1:0];
                  end
                end
                prrts_pkg::PRIO_MIN: begin
                  if (!found_min) begin
                    found_min <= 1'b1;
                    pick_min  <= sidx[IW-1:0];
                  end
                end
                default: begin
                  fault_latched <= 1'b1;
                end
              endcase
            end
            sidx <= (sidx_inc == n_active) ? '0 : sidx_inc;
            step <= step + CW'(1);
          end else begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            if (chosen_ok) begin
              running_task       <= CW'(chosen);
              task_state[chosen] <= prrts_pkg::ST_RUNNING;
              out_task           <= 3'(chosen);
              out_idle           <= 1'b0;
            end else begin
              running_task <= CW'(MAX_TASKS);
              idle_running <= 1'b1;
              out_task     <= '0;
              out_idle     <= 1'b1;
            end
            out_ticks <= tick_counter;
            out_fault <= fault_latched;
            m_tvalid  <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### test/priority_round_robin_task_scheduler_top_test.sv
`timescale 1ns / 1ps

module priority_round_robin_task_scheduler_top_test;

  localparam int NTASK = prrts_pkg::MAX_TASKS_DEF;
  localparam int SETTLE = 30;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD_LEN = 250;
  // code three is not in the package; the block treats it as a reschedule
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] ticks;
    logic        hold;
  } sched_req_t;

  typedef struct packed {
    logic [2:0]  task_id;
    logic        idle;
    logic [31:0] tick_total;
    logic        fault;
  } sched_res_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [prrts_pkg::S_DATA_W-1:0]   s_tdata = '0;
  logic [prrts_pkg::S_USER_W-1:0]   s_tuser = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [prrts_pkg::M_DATA_W-1:0]   m_tdata;
  logic [prrts_pkg::M_USER_W-1:0]   m_tuser;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [prrts_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [prrts_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [prrts_pkg::APB_DATA_W-1:0] prdata;
  logic                             pready;

  priority_round_robin_task_scheduler_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // scheduler mirror
  logic [3:0]  cfg_count = '0;
  logic [15:0] cfg_prio = '0;
  logic [1:0]  tsk_state [NTASK];
  logic [31:0] delay_rem [NTASK];
  int          cur_task = NTASK;
  logic        in_idle = 1'b0;
  logic [31:0] tick_cnt = '0;
  logic        fault_seen = 1'b0;

  sched_req_t pending_reqs [$];
  sched_res_t expected_picks [$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;

  function automatic sched_res_t pick_next(input logic [1:0] op, input logic [31:0] ticks);
    int n, idx, t, pick_hi, pick_mid, pick_lo, chosen;
    logic have;
    sched_res_t r;
    n = (cfg_count > NTASK) ? NTASK : int'(cfg_count);
    have = (cur_task < NTASK);
    pick_hi = NTASK;
    pick_mid = NTASK;
    pick_lo = NTASK;
    if (op == prrts_pkg::OP_TICK) begin
      tick_cnt = tick_cnt + 1;
      for (t = 0; t < n; t++) begin
        if (delay_rem[t] != 0) begin
          delay_rem[t] = delay_rem[t] - 1;
          if (delay_rem[t] == 0) tsk_state[t] = prrts_pkg::ST_READY;
        end
      end
    end else if (op == prrts_pkg::OP_DELAY) begin
      if (!in_idle && have && ticks != 0) begin
        delay_rem[cur_task] = ticks;
        tsk_state[cur_task] = prrts_pkg::ST_WAITING;
      end
    end
    // running task goes back to ready unless it just started waiting
    if (in_idle) begin
      in_idle = 1'b0;
    end else if (have && tsk_state[cur_task] == prrts_pkg::ST_RUNNING) begin
      tsk_state[cur_task] = prrts_pkg::ST_READY;
    end
    if (n > 0) begin
      idx = have ? (cur_task + 1) % n : 0;
      for (t = 0; t < n; t++) begin
        if (tsk_state[idx] == prrts_pkg::ST_READY) begin
          case (cfg_prio[2*idx +: 2])
            prrts_pkg::PRIO_MAX: if (pick_hi == NTASK) pick_hi = idx;
            prrts_pkg::PRIO_MED: if (pick_mid == NTASK) pick_mid = idx;
            prrts_pkg::PRIO_MIN: if (pick_lo == NTASK) pick_lo = idx;
            default: fault_seen = 1'b1;
          endcase
        end
        idx = (idx + 1) % n;
      end
    end
    chosen = (pick_hi != NTASK) ? pick_hi : (pick_mid != NTASK) ? pick_mid : pick_lo;
    if (chosen == NTASK) begin
      cur_task = NTASK;
      in_idle = 1'b1;
      r.task_id = '0;
      r.idle = 1'b1;
    end else begin
      cur_task = chosen;
      tsk_state[chosen] = prrts_pkg::ST_RUNNING;
      r.task_id = chosen[2:0];
      r.idle = 1'b0;
    end
    r.tick_total = tick_cnt;
    r.fault = fault_seen;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0h got %0h", results_seen, name, want, got);
    end
  endtask

  // driver: offers queued requests, pauses at a hold marker until all results are back
  always @(posedge clk) begin
    logic nv;
    sched_req_t nx;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_picks.push_back(pick_next(s_tuser, s_tdata));
      if (!s_tvalid || s_tready) begin
        nv = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].hold || expected_picks.size() == 0)) begin
          nx = pending_reqs.pop_front();
          s_tuser <= nx.op;
          s_tdata <= nx.ticks;
          nv = 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 5);
        end
        s_tvalid <= nv;
      end
    end
  end

  // monitor: checks each result transfer, stalls in bursts and once for a long stretch
  always @(posedge clk) begin
    sched_res_t want;
    logic rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_picks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing pending: %h / %h",
                     results_seen, m_tdata, m_tuser);
        end else begin
          want = expected_picks.pop_front();
          check_field("next_task", want.task_id, m_tdata[2:0]);
          check_field("idle_selected", want.idle, m_tuser[0]);
          check_field("tick_total", want.tick_total, m_tdata[34:3]);
          check_field("fault", want.fault, m_tdata[35]);
        end
        if (results_seen == LONG_HOLD_AT) hold_left = LONG_HOLD_LEN;
      end
      rdy = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        recv_gap = $urandom_range(1, 5) - 1;
        rdy = 1'b0;
      end
      m_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == prrts_pkg::REG_TASK_COUNT) cfg_count = val[3:0];
    else cfg_prio = val[15:0];
  endtask

  task automatic push_req(input logic [1:0] op, input logic [31:0] ticks);
    pending_reqs.push_back('{op: op, ticks: ticks, hold: 1'b0});
  endtask

  task automatic add_random_reqs(input int count, input bit with_pause);
    int i, r, s;
    sched_req_t q;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      q.op = (r < 45) ? prrts_pkg::OP_TICK :
             (r < 72) ? prrts_pkg::OP_DELAY :
             (r < 92) ? prrts_pkg::OP_RESCHED : OP_SPARE;
      q.ticks = $urandom;
      if (q.op == prrts_pkg::OP_DELAY) begin
        // mostly short waits so tasks keep coming back
        s = $urandom_range(0, 199);
        if (s < 10) q.ticks = '0;
        else if (s < 186) q.ticks = $urandom_range(1, 6);
        else if (s < 196) q.ticks = $urandom_range(7, 40);
        else if (s == 199) q.ticks = '1;
      end
      q.hold = with_pause && (i == count / 2);
      pending_reqs.push_back(q);
    end
  endtask

  function automatic logic [15:0] random_prio(input bit allow_bad);
    logic [15:0] p;
    int t;
    for (t = 0; t < 8; t++)
      p[2*t +: 2] = allow_bad ? 2'($urandom_range(0, 3)) : 2'($urandom_range(0, 2));
    return p;
  endfunction

  task automatic wait_drained;
    while (pending_reqs.size() != 0 || s_tvalid || expected_picks.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] count, input logic [15:0] prio);
    reg_write(prrts_pkg::REG_TASK_COUNT, {28'($urandom), count});
    reg_write(prrts_pkg::REG_TASK_PRIO, {16'($urandom), prio});
  endtask

  task automatic random_phase(input logic [3:0] count, input logic [15:0] prio, input int n,
                              input bit with_pause);
    set_config(count, prio);
    add_random_reqs(n, with_pause);
    wait_drained();
  endtask

  initial begin
    int t;
    for (t = 0; t < NTASK; t++) begin
      tsk_state[t] = prrts_pkg::ST_READY;
      delay_rem[t] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // no tasks: everything lands on idle, delay is ignored
    set_config(4'd0, 16'h0000);
    push_req(prrts_pkg::OP_TICK, 32'hFFFF_FFFF);
    push_req(prrts_pkg::OP_DELAY, 32'd5);
    push_req(prrts_pkg::OP_RESCHED, 32'h0000_0000);
    push_req(OP_SPARE, 32'h5A5A_A5A5);
    wait_drained();

    // all eight tasks with mixed priorities, scan starts at zero
    set_config(4'd8, 16'h4624);
    push_req(prrts_pkg::OP_RESCHED, 32'd0);
    push_req(prrts_pkg::OP_DELAY, 32'd0);
    push_req(prrts_pkg::OP_DELAY, 32'd3);
    push_req(prrts_pkg::OP_DELAY, 32'hFFFF_FFFF);
    push_req(prrts_pkg::OP_TICK, 32'd0);
    push_req(prrts_pkg::OP_TICK, 32'd7);
    push_req(prrts_pkg::OP_TICK, 32'd1);
    push_req(OP_SPARE, 32'd0);
    push_req(prrts_pkg::OP_RESCHED, 32'd0);
    wait_drained();

    // shrink below the running task, then a count above the maximum
    set_config(4'd3, 16'h4624);
    push_req(prrts_pkg::OP_RESCHED, 32'd0);
    push_req(prrts_pkg::OP_TICK, 32'd0);
    push_req(prrts_pkg::OP_DELAY, 32'd1);
    push_req(prrts_pkg::OP_TICK, 32'd0);
    wait_drained();
    set_config(4'd15, 16'h4624);
    push_req(prrts_pkg::OP_RESCHED, 32'd0);
    push_req(prrts_pkg::OP_TICK, 32'd0);
    wait_drained();

    random_phase(4'd8, random_prio(1'b0), 200, 1'b0);
    random_phase(4'd1, random_prio(1'b0), 60, 1'b0);
    random_phase(4'd2, random_prio(1'b0), 80, 1'b1);
    random_phase(4'd8, random_prio(1'b0), 200, 1'b1);
    random_phase(4'd5, 16'h0000, 120, 1'b0);
    random_phase(4'd15, 16'hAAAA, 120, 1'b0);
    random_phase(4'd0, random_prio(1'b0), 20, 1'b0);
    random_phase(4'd3, random_prio(1'b0), 80, 1'b0);

    // invalid priority code on a ready task latches the fault for good
    set_config(4'd4, 16'h0030);
    push_req(prrts_pkg::OP_RESCHED, 32'd0);
    push_req(prrts_pkg::OP_RESCHED, 32'd0);
    push_req(prrts_pkg::OP_TICK, 32'd0);
    push_req(prrts_pkg::OP_DELAY, 32'd2);
    wait_drained();

    random_phase(4'd8, random_prio(1'b1), 150, 1'b0);
    random_phase(4'd6, 16'hFFFF, 30, 1'b0);
    calm = 1'b1;
    random_phase(4'd8, random_prio(1'b0), 200, 1'b0);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
